// ===== sv/i2cm_pkg.sv =====
// Shared types and constants for the bit-level I2C master.
`default_nettype none

package i2cm_pkg;

  // Reset value of the half period register, in ticks.
  localparam logic [7:0] HALF_PERIOD_RESET = 8'd10;

  // Number of bits moved by a byte command.
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Depth of the queue between the front and the bus engine.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_WRITE   = 3'd3,
    CMD_READ    = 3'd4,
    CMD_ACK     = 3'd5,
    CMD_NACK    = 3'd6,
    CMD_WAITACK = 3'd7
  } cmd_t;

  // Step within the active command.
  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_C = 2'd2,
    PH_D = 2'd3
  } phase_t;

  // One classified tick request.
  typedef struct packed {
    cmd_t       cmd;
    logic       has_cmd;
    logic [7:0] tx_byte;
    logic       sda_in;
  } tick_t;

  // One result of a tick.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
    logic       bus_busy;
    logic       cmd_dropped;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/i2cm_front.sv =====
// Front stage: accepts tick requests, classifies the command and holds them for the queue.
`default_nettype none

module i2cm_front
  import i2cm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] cmd,
  input  wire logic [7:0] tx_byte,
  input  wire logic       sda_in,
  output logic            push_valid,
  input  wire logic       push_ready,
  output tick_t           push_item
);

  logic  hold_valid;
  tick_t hold_item;
  tick_t classified;

  always_comb begin
    classified.cmd     = cmd_t'(cmd);
    classified.has_cmd = (cmd_t'(cmd) != CMD_NONE);
    classified.tx_byte = tx_byte;
    classified.sda_in  = sda_in;
  end

  // Take a new request when nothing is held or when the held one leaves in the same cycle.
  assign in_ready   = !hold_valid || push_ready;
  assign push_valid = hold_valid;
  assign push_item  = hold_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= classified;
    end
  end

endmodule

`default_nettype wire

// ===== sv/i2cm_queue.sv =====
// Short request queue between the front stage and the bus engine.
`default_nettype none

module i2cm_queue
  import i2cm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire tick_t push_item,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output tick_t      pop_item
);

  tick_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_CW-1:0]  count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (count != QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QUEUE_CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QUEUE_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== sv/i2cm_engine.sv =====
// Bus engine: runs the command steps one tick per request and registers the result.
`default_nettype none

module i2cm_engine
  import i2cm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  input  wire logic       pop_valid,
  output logic            pop_ready,
  input  wire tick_t      pop_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output result_t         out_res
);

  logic [7:0] half_period;
  logic [7:0] half_eff;

  logic       busy,          busy_next;
  cmd_t       active,        active_next;
  phase_t     phase,         phase_next;
  logic [3:0] bit_count,     bit_count_next;
  logic [7:0] shift_reg,     shift_reg_next;
  logic [7:0] tick_count,    tick_count_next;
  logic       scl_level,     scl_level_next;
  logic       sda_level,     sda_level_next;
  logic [7:0] received_byte, received_byte_next;
  logic       ack_flag,      ack_flag_next;

  logic       done;
  logic       aborted;
  logic       dropped;
  logic       fire;
  result_t    res_next;

  assign cfg_ready = 1'b1;
  assign half_eff  = (half_period == 8'd0) ? 8'd1 : half_period;
  assign fire      = pop_valid && (!out_valid || out_ready);
  assign pop_ready = !out_valid || out_ready;

  // Next state for one tick.
  always_comb begin
    logic [7:0] tc;
    logic       finish;
    logic       abort;

    busy_next          = busy;
    active_next        = active;
    phase_next         = phase;
    bit_count_next     = bit_count;
    shift_reg_next     = shift_reg;
    tick_count_next    = tick_count;
    scl_level_next     = scl_level;
    sda_level_next     = sda_level;
    received_byte_next = received_byte;
    ack_flag_next      = ack_flag;
    done               = 1'b0;
    aborted            = 1'b0;
    dropped            = 1'b0;
    finish             = 1'b0;
    abort              = 1'b0;
    tc                 = tick_count + 8'd1;

    if (busy) begin
      dropped = pop_item.has_cmd;
      if (tc >= half_eff) begin
        tick_count_next = '0;
        unique case (active)
          CMD_START: begin
            if (phase == PH_A) begin
              if (!pop_item.sda_in) begin
                abort = 1'b1;
              end else begin
                sda_level_next = 1'b0;
                phase_next     = PH_B;
              end
            end else if (phase == PH_B) begin
              scl_level_next = 1'b0;
              phase_next     = PH_C;
            end else begin
              finish = 1'b1;
            end
          end
          CMD_STOP: begin
            if (phase == PH_A) begin
              scl_level_next = 1'b1;
              phase_next     = PH_B;
            end else if (phase == PH_B) begin
              sda_level_next = 1'b1;
              phase_next     = PH_C;
            end else begin
              finish = 1'b1;
            end
          end
          CMD_ACK, CMD_NACK: begin
            if (phase == PH_A) begin
              sda_level_next = (active == CMD_NACK);
              phase_next     = PH_B;
            end else if (phase == PH_B) begin
              scl_level_next = 1'b1;
              phase_next     = PH_C;
            end else if (phase == PH_C) begin
              scl_level_next = 1'b0;
              phase_next     = PH_D;
            end else begin
              finish = 1'b1;
            end
          end
          CMD_WAITACK: begin
            if (phase == PH_A) begin
              sda_level_next = 1'b1;
              phase_next     = PH_B;
            end else if (phase == PH_B) begin
              scl_level_next = 1'b1;
              phase_next     = PH_C;
            end else begin
              // Ack is SDA pulled low while SCL is high.
              ack_flag_next  = !pop_item.sda_in;
              scl_level_next = 1'b0;
              finish         = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (phase == PH_A) begin
              sda_level_next = shift_reg[7];
              shift_reg_next = {shift_reg[6:0], 1'b0};
              phase_next     = PH_B;
            end else if (phase == PH_B) begin
              scl_level_next = 1'b1;
              phase_next     = PH_C;
            end else begin
              bit_count_next = bit_count + 4'd1;
              scl_level_next = 1'b0;
              phase_next     = PH_A;
              finish         = (bit_count_next >= BITS_PER_BYTE);
            end
          end
          CMD_READ: begin
            if (phase == PH_A) begin
              scl_level_next = 1'b1;
              phase_next     = PH_B;
            end else begin
              shift_reg_next = {shift_reg[6:0], pop_item.sda_in};
              bit_count_next = bit_count + 4'd1;
              scl_level_next = 1'b0;
              phase_next     = PH_A;
              if (bit_count_next >= BITS_PER_BYTE) begin
                received_byte_next = shift_reg_next;
                finish             = 1'b1;
              end
            end
          end
          CMD_NONE: begin
            finish = 1'b1;
          end
        endcase
        if (finish || abort) begin
          done       = 1'b1;
          aborted    = abort;
          busy_next  = 1'b0;
          phase_next = PH_A;
        end
      end else begin
        tick_count_next = tc;
      end
    end else if (pop_item.has_cmd) begin
      // Drive the first step on the tick the command arrives.
      active_next     = pop_item.cmd;
      phase_next      = PH_A;
      tick_count_next = '0;
      bit_count_next  = '0;
      busy_next       = 1'b1;
      unique case (pop_item.cmd)
        CMD_START: begin
          sda_level_next = 1'b1;
          scl_level_next = 1'b1;
        end
        CMD_STOP: begin
          sda_level_next = 1'b0;
          scl_level_next = 1'b0;
        end
        CMD_WRITE: begin
          shift_reg_next = pop_item.tx_byte;
          scl_level_next = 1'b0;
        end
        CMD_READ: begin
          shift_reg_next = '0;
          sda_level_next = 1'b1;
          scl_level_next = 1'b0;
        end
        CMD_ACK, CMD_NACK, CMD_WAITACK, CMD_NONE: begin
          scl_level_next = 1'b0;
        end
      endcase
    end
  end

  // Result of the tick.
  always_comb begin
    res_next.scl_out     = scl_level_next;
    res_next.sda_out     = sda_level_next;
    res_next.busy_res    = busy_next;
    res_next.done_res    = done;
    res_next.rx_byte     = received_byte_next;
    res_next.ack_seen    = ack_flag_next;
    res_next.bus_busy    = aborted;
    res_next.cmd_dropped = dropped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period   <= HALF_PERIOD_RESET;
      busy          <= 1'b0;
      active        <= CMD_NONE;
      phase         <= PH_A;
      bit_count     <= '0;
      shift_reg     <= '0;
      tick_count    <= '0;
      scl_level     <= 1'b1;
      sda_level     <= 1'b1;
      received_byte <= '0;
      ack_flag      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        half_period <= cfg_data;
      end
      if (fire) begin
        busy          <= busy_next;
        active        <= active_next;
        phase         <= phase_next;
        bit_count     <= bit_count_next;
        shift_reg     <= shift_reg_next;
        tick_count    <= tick_count_next;
        scl_level     <= scl_level_next;
        sda_level     <= sda_level_next;
        received_byte <= received_byte_next;
        ack_flag      <= ack_flag_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/i2c_bit_level_master.sv =====
// Top level of the bit-level I2C master: front stage, request queue and bus engine.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid/in_ready, cmd, tx_byte, sda_in   | request in
//   out     | out_valid/out_ready, scl_out .. cmd_dropped | result out
//   cfg     | cfg_valid/cfg_ready, cfg_data             | half period write
//
// One request per clock is taken and one result per clock delivered when neither
// side stalls; a taken request passes the front hold register and a queue entry
// before it reaches the output register. The bus engine updates its step state
// once per request, which sets the rate. Reset (rst, synchronous) empties the queue and
// output register and sets the half period to 10 ticks. A stalled output backs up the
// four-entry queue, then the front stage, and only then drops in_ready.
`default_nettype none

module i2c_bit_level_master
  import i2cm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] cmd,
  input  wire logic [7:0] tx_byte,
  input  wire logic       sda_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            scl_out,
  output logic            sda_out,
  output logic            busy_res,
  output logic            done_res,
  output logic [7:0]      rx_byte,
  output logic            ack_seen,
  output logic            bus_busy,
  output logic            cmd_dropped
);

  logic    push_valid;
  logic    push_ready;
  tick_t   push_item;
  logic    pop_valid;
  logic    pop_ready;
  tick_t   pop_item;
  result_t res;

  i2cm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .tx_byte    (tx_byte),
    .sda_in     (sda_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  i2cm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  i2cm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign scl_out     = res.scl_out;
  assign sda_out     = res.sda_out;
  assign busy_res    = res.busy_res;
  assign done_res    = res.done_res;
  assign rx_byte     = res.rx_byte;
  assign ack_seen    = res.ack_seen;
  assign bus_busy    = res.bus_busy;
  assign cmd_dropped = res.cmd_dropped;

endmodule

`default_nettype wire

// ===== dv/tb_i2c_bit_level_master.sv =====
// Self-checking testbench for the bit-level I2C master: tick requests in, line results out.
`timescale 1ns / 100ps

module tb_i2c_bit_level_master;
  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TICKS = 8;
  localparam int PRINT_LIMIT  = 40;

  // Engine state as the bus sees it, one copy per user.
  typedef struct {
    logic [7:0] half;
    phase_t     phase;
    cmd_t       active;
    logic [3:0] bits;
    logic [7:0] shifter;
    logic [7:0] ticks;
    logic       scl;
    logic       sda;
    logic [7:0] rx;
    logic       ack;
    logic       busy;
  } bus_engine_t;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] tx;
    logic       sda;
  } tick_req_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] cmd = CMD_NONE;
  logic [7:0] tx_byte = 8'd0;
  logic       sda_in = 1'b1;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_seen;
  logic       bus_busy;
  logic       cmd_dropped;

  bus_engine_t bus_model;
  bus_engine_t plan_model;
  tick_req_t   ticks_pending[$];
  result_t     line_results_due[$];

  int  send_idle_pct = 10;
  int  recv_idle_pct = 50;
  int  ticks_queued = 0;
  int  results_seen = 0;
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  in_taken = 1'b0;

  i2c_bit_level_master dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .tx_byte     (tx_byte),
    .sda_in      (sda_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .scl_out     (scl_out),
    .sda_out     (sda_out),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .rx_byte     (rx_byte),
    .ack_seen    (ack_seen),
    .bus_busy    (bus_busy),
    .cmd_dropped (cmd_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void engine_clear(inout bus_engine_t e);
    e.half    = HALF_PERIOD_RESET;
    e.phase   = PH_A;
    e.active  = CMD_NONE;
    e.bits    = 4'd0;
    e.shifter = 8'd0;
    e.ticks   = 8'd0;
    e.scl     = 1'b1;
    e.sda     = 1'b1;
    e.rx      = 8'd0;
    e.ack     = 1'b0;
    e.busy    = 1'b0;
  endfunction

  // End of one half phase: 0 go on, 1 command finished, 2 start aborted.
  function automatic int half_phase_end(inout bus_engine_t e, input logic sda);
    case (e.active)
      CMD_START: begin
        if (e.phase == PH_A) begin
          if (!sda) return 2;
          e.sda = 1'b0;
          e.phase = PH_B;
          return 0;
        end
        if (e.phase == PH_B) begin
          e.scl = 1'b0;
          e.phase = PH_C;
          return 0;
        end
        return 1;
      end
      CMD_STOP: begin
        if (e.phase == PH_A) begin
          e.scl = 1'b1;
          e.phase = PH_B;
          return 0;
        end
        if (e.phase == PH_B) begin
          e.sda = 1'b1;
          e.phase = PH_C;
          return 0;
        end
        return 1;
      end
      CMD_ACK, CMD_NACK: begin
        case (e.phase)
          PH_A: begin
            e.sda = (e.active == CMD_NACK);
            e.phase = PH_B;
          end
          PH_B: begin
            e.scl = 1'b1;
            e.phase = PH_C;
          end
          PH_C: begin
            e.scl = 1'b0;
            e.phase = PH_D;
          end
          default: return 1;
        endcase
        return 0;
      end
      CMD_WAITACK: begin
        if (e.phase == PH_A) begin
          e.sda = 1'b1;
          e.phase = PH_B;
          return 0;
        end
        if (e.phase == PH_B) begin
          e.scl = 1'b1;
          e.phase = PH_C;
          return 0;
        end
        e.ack = !sda;
        e.scl = 1'b0;
        return 1;
      end
      CMD_WRITE: begin
        if (e.phase == PH_A) begin
          e.sda = e.shifter[7];
          e.shifter = {e.shifter[6:0], 1'b0};
          e.phase = PH_B;
          return 0;
        end
        if (e.phase == PH_B) begin
          e.scl = 1'b1;
          e.phase = PH_C;
          return 0;
        end
        e.bits = e.bits + 4'd1;
        e.scl = 1'b0;
        e.phase = PH_A;
        return (e.bits >= BITS_PER_BYTE) ? 1 : 0;
      end
      CMD_READ: begin
        if (e.phase == PH_A) begin
          e.scl = 1'b1;
          e.phase = PH_B;
          return 0;
        end
        e.shifter = {e.shifter[6:0], sda};
        e.bits = e.bits + 4'd1;
        e.scl = 1'b0;
        e.phase = PH_A;
        if (e.bits >= BITS_PER_BYTE) begin
          e.rx = e.shifter;
          return 1;
        end
        return 0;
      end
      default: return 1;
    endcase
  endfunction

  // Advance the engine by one tick and return the line result of that tick.
  function automatic result_t bus_tick(inout bus_engine_t e, input cmd_t c,
                                       input logic [7:0] tx, input logic sda);
    result_t    r;
    logic [7:0] h;
    int         fin;
    r = '0;
    h = (e.half == 8'd0) ? 8'd1 : e.half;
    if (e.busy) begin
      r.cmd_dropped = (c != CMD_NONE);
      e.ticks = e.ticks + 8'd1;
      if (e.ticks >= h) begin
        e.ticks = 8'd0;
        fin = half_phase_end(e, sda);
        if (fin != 0) begin
          r.done_res = 1'b1;
          r.bus_busy = (fin == 2);
          e.busy = 1'b0;
          e.phase = PH_A;
        end
      end
    end else if (c != CMD_NONE) begin
      e.active = c;
      e.phase  = PH_A;
      e.ticks  = 8'd0;
      e.bits   = 4'd0;
      e.busy   = 1'b1;
      case (c)
        CMD_START: begin
          e.sda = 1'b1;
          e.scl = 1'b1;
        end
        CMD_STOP: begin
          e.sda = 1'b0;
          e.scl = 1'b0;
        end
        CMD_WRITE: begin
          e.shifter = tx;
          e.scl = 1'b0;
        end
        CMD_READ: begin
          e.shifter = 8'd0;
          e.sda = 1'b1;
          e.scl = 1'b0;
        end
        default: e.scl = 1'b0;
      endcase
    end
    r.scl_out  = e.scl;
    r.sda_out  = e.sda;
    r.busy_res = e.busy;
    r.rx_byte  = e.rx;
    r.ack_seen = e.ack;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Queue one tick request and track where the engine will be after it.
  task automatic plan_tick(input cmd_t c, input logic [7:0] tx, input logic sda);
    tick_req_t req;
    result_t   unused;
    req.cmd = c;
    req.tx  = tx;
    req.sda = sda;
    ticks_pending.push_back(req);
    unused = bus_tick(plan_model, c, tx, sda);
    ticks_queued++;
  endtask

  // Issue one command and hold the given SDA level until it finishes.
  task automatic run_command(input cmd_t c, input logic [7:0] tx, input logic sda,
                             input bit noisy);
    plan_tick(c, tx, sda);
    while (plan_model.busy)
      plan_tick(noisy ? cmd_t'($urandom_range(1, 7)) : CMD_NONE, tx, sda);
  endtask

  task automatic random_ticks(input int n);
    cmd_t c;
    repeat (n) begin
      if (!plan_model.busy)
        c = ($urandom_range(0, 99) < 80) ? cmd_t'($urandom_range(1, 7)) : CMD_NONE;
      else
        c = ($urandom_range(0, 99) < 5) ? cmd_t'($urandom_range(1, 7)) : CMD_NONE;
      plan_tick(c, 8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0);
    end
    // let the last command finish so the register can be changed at rest
    while (plan_model.busy)
      plan_tick(CMD_NONE, 8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0);
  endtask

  task automatic drain;
    wait (results_seen == ticks_queued);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic set_half_period(input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    bus_model.half  = value;
    plan_model.half = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Request driver: hold until taken, then pull the next tick or idle.
  always @(negedge clk) begin
    tick_req_t req;
    if (!rst && (!in_valid || in_taken)) begin
      if (ticks_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req = ticks_pending.pop_front();
        in_valid <= 1'b1;
        cmd      <= req.cmd;
        tx_byte  <= req.tx;
        sda_in   <= req.sda;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk) begin
    result_t want;
    in_taken = in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready)
        line_results_due.push_back(bus_tick(bus_model, cmd_t'(cmd), tx_byte, sda_in));
      if (out_valid && out_ready) begin
        results_seen++;
        if (line_results_due.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = line_results_due.pop_front();
          check_field("scl_out", scl_out, want.scl_out);
          check_field("sda_out", sda_out, want.sda_out);
          check_field("busy_res", busy_res, want.busy_res);
          check_field("done_res", done_res, want.done_res);
          check_field("rx_byte", rx_byte, want.rx_byte);
          check_field("ack_seen", ack_seen, want.ack_seen);
          check_field("bus_busy", bus_busy, want.bus_busy);
          check_field("cmd_dropped", cmd_dropped, want.cmd_dropped);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    engine_clear(bus_model);
    engine_clear(plan_model);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset half period
    run_command(CMD_STOP, 8'h00, 1'b1, 1'b0);
    drain();

    set_half_period(8'd1);
    plan_tick(CMD_NONE, 8'hA5, 1'b0);
    run_command(CMD_START, 8'h00, 1'b1, 1'b0);
    run_command(CMD_START, 8'hFF, 1'b0, 1'b0);   // SDA held low: bus busy
    run_command(CMD_WRITE, 8'h00, 1'b1, 1'b0);
    run_command(CMD_WRITE, 8'hFF, 1'b0, 1'b0);
    run_command(CMD_WRITE, 8'h5A, 1'b1, 1'b1);   // dropped commands, done tick too
    run_command(CMD_WAITACK, 8'h00, 1'b0, 1'b0);
    run_command(CMD_READ, 8'h00, 1'b1, 1'b0);
    run_command(CMD_READ, 8'hFF, 1'b0, 1'b0);
    run_command(CMD_ACK, 8'h00, 1'b1, 1'b0);
    run_command(CMD_NACK, 8'h00, 1'b0, 1'b0);
    run_command(CMD_WAITACK, 8'h00, 1'b1, 1'b0);
    run_command(CMD_STOP, 8'h00, 1'b1, 1'b1);
    plan_tick(CMD_NONE, 8'h5A, 1'b1);
    random_ticks(90);
    drain();

    send_idle_pct = 50;
    recv_idle_pct = 10;
    set_half_period(8'd0);                        // zero acts as one tick
    random_ticks(60);
    drain();
    set_half_period(8'd3);
    random_ticks(70);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_half_period(8'd2);
    random_ticks(80);
    drain();

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/i2cm_pkg.sv
sv/i2cm_front.sv
sv/i2cm_queue.sv
sv/i2cm_engine.sv
sv/i2c_bit_level_master.sv
dv/tb_i2c_bit_level_master.sv
